>>> src/itra_pkg.sv
// Shared constants, types and the digit-to-character function of the radix converter.
package itra_pkg;

    localparam int VALUE_BITS = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;

    // The long division by the radix retires DIV_BITS dividend bits per cycle.
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int CNT_W     = $clog2(VALUE_BITS + 1);
    localparam int IDX_W     = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] DEC_RADIX = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_A     = CHAR_W'(65);
    localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);
    localparam logic [CHAR_W-1:0] ASCII_NINE  = CHAR_W'(57);
    localparam logic [CHAR_W-1:0] ASCII_Z     = CHAR_W'(90);

    typedef struct packed {
        logic [VALUE_BITS-1:0] magnitude;
        logic [RADIX_W-1:0]    radix;
        logic                  sign;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_fifo_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_DIGIT
    } t_back_state;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] digit);
        logic [CHAR_W-1:0] wide;
        wide = CHAR_W'(digit);
        if (digit < DEC_RADIX) begin
            return wide + ASCII_ZERO;
        end else begin
            return wide - CHAR_W'(DEC_RADIX) + ASCII_A;
        end
    endfunction

endpackage

>>> src/itra_in_if.sv
// Input channel: a signed value and the radix it is to be written in.
interface itra_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [itra_pkg::VALUE_BITS-1:0] value;
    logic [itra_pkg::RADIX_W-1:0]        radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

>>> src/itra_out_if.sv
// Output channel: one ASCII character per item, with a flag on the final one.
interface itra_out_if;
    logic                        valid;
    logic                        ready;
    logic [itra_pkg::CHAR_W-1:0] character;
    logic                        last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

>>> src/itra_front.sv
// Front end: takes input items, clamps the radix and splits the value into sign and magnitude.
module itra_front (
    itra_in_if.sink                   i_in,
    input  itra_pkg::t_fifo_status    i_status,
    output itra_pkg::t_push           o_push
);

    logic                              neg;
    logic [itra_pkg::VALUE_BITS-1:0]   raw;
    logic [itra_pkg::RADIX_W-1:0]      radix_sat;

    assign i_in.ready = !i_status.full;

    assign raw = i_in.value;
    assign neg = raw[itra_pkg::VALUE_BITS-1];

    always_comb begin
        priority if (i_in.radix < itra_pkg::RADIX_MIN) begin
            radix_sat = itra_pkg::RADIX_MIN;
        end else if (i_in.radix > itra_pkg::RADIX_MAX) begin
            radix_sat = itra_pkg::RADIX_MAX;
        end else begin
            radix_sat = i_in.radix;
        end
    end

    // The most negative value negates to itself, which read unsigned is the right magnitude.
    always_comb begin
        o_push.valid         = i_in.valid && !i_status.full;
        o_push.cmd.magnitude = neg ? (~raw + itra_pkg::VALUE_BITS'(1)) : raw;
        o_push.cmd.radix     = radix_sat;
        o_push.cmd.sign      = neg && (radix_sat == itra_pkg::DEC_RADIX);
    end

endmodule

>>> src/itra_cmd_fifo.sv
// Two-entry queue of classified items between the front end and the digit engine.
module itra_cmd_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  itra_pkg::t_push        i_push,
    input  logic                   i_pop,
    output itra_pkg::t_cmd         o_cmd,
    output itra_pkg::t_fifo_status o_status
);

    itra_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    always_comb begin
        n_count = r_count;
        unique case ({i_push.valid, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_cmd              = r_mem[r_rd_ptr];
    assign o_status.not_empty = (r_count != 2'd0);
    assign o_status.full      = (r_count == 2'd2);

endmodule

>>> src/itra_back.sv
// Digit engine: divides the magnitude by the radix digit by digit, then sends the characters.
module itra_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  itra_pkg::t_cmd         i_cmd,
    input  itra_pkg::t_fifo_status i_status,
    output logic                   o_pop,
    itra_out_if.source             o_out
);

    itra_pkg::t_back_state r_state;
    itra_pkg::t_back_state n_state;

    logic [itra_pkg::PAD_W-1:0]   r_quo;
    logic [itra_pkg::RADIX_W-1:0] r_rem;
    logic [itra_pkg::RADIX_W-1:0] r_radix;
    logic                         r_sign;
    logic [itra_pkg::STEP_W-1:0]  r_step;
    logic [itra_pkg::CNT_W-1:0]   r_count;
    logic [itra_pkg::CNT_W-1:0]   r_rd_idx;
    logic [itra_pkg::RADIX_W-1:0] r_digits [itra_pkg::VALUE_BITS];

    logic                         r_out_valid;
    logic [itra_pkg::CHAR_W-1:0]  r_out_char;
    logic                         r_out_last;

    logic [itra_pkg::PAD_W-1:0]   step_quo;
    logic [itra_pkg::RADIX_W-1:0] step_rem;
    logic [itra_pkg::CNT_W-1:0]   count_inc;
    logic [itra_pkg::CNT_W-1:0]   rd_prev;
    logic                         div_last;
    logic                         div_done;
    logic                         out_free;
    logic                         cmd_pop;
    logic                         out_load;
    logic                         out_sign;

    // One slice of restoring division: the remainder stays below the radix, so it is narrow.
    always_comb begin
        logic [itra_pkg::PAD_W-1:0]   q;
        logic [itra_pkg::RADIX_W-1:0] rem;
        logic [itra_pkg::RADIX_W:0]   trial;
        q   = r_quo;
        rem = r_rem;
        for (int i = 0; i < itra_pkg::DIV_BITS; i++) begin
            trial = {rem, q[itra_pkg::PAD_W-1]};
            q     = {q[itra_pkg::PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_radix}) begin
                trial = trial - {1'b0, r_radix};
                q[0]  = 1'b1;
            end
            rem = trial[itra_pkg::RADIX_W-1:0];
        end
        step_quo = q;
        step_rem = rem;
    end

    assign count_inc = r_count + itra_pkg::CNT_W'(1);
    assign rd_prev   = r_rd_idx - itra_pkg::CNT_W'(1);
    assign div_last  = (r_step == itra_pkg::STEP_W'(itra_pkg::DIV_STEPS - 1));
    assign div_done  = div_last && ((step_quo == '0)
                       || (count_inc == itra_pkg::CNT_W'(itra_pkg::VALUE_BITS)));
    assign out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itra_pkg::ST_IDLE: begin
                if (i_status.not_empty) begin
                    n_state = itra_pkg::ST_DIV;
                end
            end
            itra_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = r_sign ? itra_pkg::ST_SIGN : itra_pkg::ST_DIGIT;
                end
            end
            itra_pkg::ST_SIGN: begin
                if (out_free) begin
                    n_state = itra_pkg::ST_DIGIT;
                end
            end
            itra_pkg::ST_DIGIT: begin
                if (out_free && (r_rd_idx == itra_pkg::CNT_W'(1))) begin
                    n_state = itra_pkg::ST_IDLE;
                end
            end
            default: n_state = itra_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop  = 1'b0;
        out_load = 1'b0;
        out_sign = 1'b0;
        unique case (r_state)
            itra_pkg::ST_IDLE:  cmd_pop = i_status.not_empty;
            itra_pkg::ST_DIV:   cmd_pop = 1'b0;
            itra_pkg::ST_SIGN: begin
                out_load = out_free;
                out_sign = 1'b1;
            end
            itra_pkg::ST_DIGIT: out_load = out_free;
            default:            cmd_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itra_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_pop) begin
            r_quo   <= itra_pkg::PAD_W'(i_cmd.magnitude);
            r_rem   <= '0;
            r_radix <= i_cmd.radix;
            r_sign  <= i_cmd.sign;
            r_step  <= '0;
            r_count <= '0;
        end else if (r_state == itra_pkg::ST_DIV) begin
            r_quo <= step_quo;
            if (div_last) begin
                // Digits are stored least significant first and read back in reverse.
                r_digits[r_count[itra_pkg::IDX_W-1:0]] <= step_rem;
                r_count  <= count_inc;
                r_rd_idx <= count_inc;
                r_rem    <= '0;
                r_step   <= '0;
            end else begin
                r_rem  <= step_rem;
                r_step <= r_step + itra_pkg::STEP_W'(1);
            end
        end
        if (out_load) begin
            if (out_sign) begin
                r_out_char <= itra_pkg::ASCII_MINUS;
                r_out_last <= 1'b0;
            end else begin
                r_out_char <= itra_pkg::digit_to_ascii(r_digits[rd_prev[itra_pkg::IDX_W-1:0]]);
                r_out_last <= (r_rd_idx == itra_pkg::CNT_W'(1));
                r_rd_idx   <= rd_prev;
            end
        end
    end

    assign o_pop           = cmd_pop;
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last      = r_out_last;

endmodule

>>> src/integer_to_radix_ascii.sv
// Top level of the signed integer to ASCII radix converter.
//
// Input channel i_in carries a signed VALUE_BITS-bit value and a radix (2 to 36; codes
// below are read as 2 and above as 36). Output channel o_out sends the number's ASCII
// characters most significant first, digits 0-9 then A-Z, with last high on the final
// one. A negative value gets a leading '-' only in base 10; in other bases its
// magnitude is written unsigned. Zero gives a single '0'.
// An item is taken into a two-entry queue as soon as there is room, so up to two items
// wait while the digit engine works on a third. For each item the engine loads it from
// the queue, divides the magnitude by the radix digit by digit (eight dividend bits per
// cycle through one shared divider slice), then sends the sign, if any, and the digits.
// It takes the next item only once the last character of this one is in the output register.
// When the receiver holds ready low the output register keeps its character and the
// engine waits; the queue keeps taking items until it is full.
// Reset (synchronous, active low) empties the queue and the output register and
// returns the engine to idle; no clearing pass is needed.
module integer_to_radix_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itra_in_if.sink     i_in,
    itra_out_if.source  o_out
);

    itra_pkg::t_push        push;
    itra_pkg::t_cmd         cmd;
    itra_pkg::t_fifo_status status;
    logic                   pop;

    itra_front u_front (
        .i_in     (i_in),
        .i_status (status),
        .o_push   (push)
    );

    itra_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_cmd    (cmd),
        .o_status (status)
    );

    itra_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_status (status),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push.valid && status.full))
        else $error("Item written into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> status.not_empty)
        else $error("Item taken from an empty queue.");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.character == itra_pkg::ASCII_MINUS)) |-> !o_out.last)
        else $error("Minus sign flagged as the final character.");

    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ((o_out.character == itra_pkg::ASCII_MINUS)
            || ((o_out.character >= itra_pkg::ASCII_ZERO)
                && (o_out.character <= itra_pkg::ASCII_NINE))
            || ((o_out.character >= itra_pkg::ASCII_A)
                && (o_out.character <= itra_pkg::ASCII_Z))))
        else $error("Character outside the digit and sign set.");

endmodule

>>> verif/integer_to_radix_ascii_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the integer to radix ASCII converter with a character scoreboard.
module integer_to_radix_ascii_tb;

    localparam int CLK_HALF     = 4;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;

    localparam logic signed [itra_pkg::VALUE_BITS-1:0] MOST_NEG =
        {1'b1, {(itra_pkg::VALUE_BITS-1){1'b0}}};
    localparam logic signed [itra_pkg::VALUE_BITS-1:0] MOST_POS =
        {1'b0, {(itra_pkg::VALUE_BITS-1){1'b1}}};

    // Holds the characters still owed by the block and checks each one as it leaves.
    class ascii_digit_board;
        typedef struct packed {
            logic [itra_pkg::CHAR_W-1:0] character;
            logic                        last;
        } t_char;

        t_char       pending_chars[$];
        int unsigned mismatches;
        int unsigned chars_checked;

        function void note_value(input logic signed [itra_pkg::VALUE_BITS-1:0] value,
                                 input logic [itra_pkg::RADIX_W-1:0] radix);
            logic [itra_pkg::VALUE_BITS-1:0] magnitude;
            logic [itra_pkg::RADIX_W-1:0]    base;
            logic [itra_pkg::RADIX_W-1:0]    digits[$];
            t_char                           item;
            base = (radix < itra_pkg::RADIX_MIN) ? itra_pkg::RADIX_MIN :
                   ((radix > itra_pkg::RADIX_MAX) ? itra_pkg::RADIX_MAX : radix);
            magnitude = value;
            if (value[itra_pkg::VALUE_BITS-1]) begin
                magnitude = ~magnitude + 1'b1;
            end
            do begin
                digits.push_front(itra_pkg::RADIX_W'(
                    magnitude % itra_pkg::VALUE_BITS'(base)));
                magnitude = magnitude / itra_pkg::VALUE_BITS'(base);
            end while (magnitude != 0);
            if (value[itra_pkg::VALUE_BITS-1] && base == itra_pkg::DEC_RADIX) begin
                item.character = itra_pkg::ASCII_MINUS;
                item.last      = 1'b0;
                pending_chars.push_back(item);
            end
            foreach (digits[i]) begin
                if (digits[i] < itra_pkg::DEC_RADIX) begin
                    item.character = itra_pkg::ASCII_ZERO + itra_pkg::CHAR_W'(digits[i]);
                end else begin
                    item.character = itra_pkg::ASCII_A + itra_pkg::CHAR_W'(digits[i])
                                     - itra_pkg::CHAR_W'(itra_pkg::DEC_RADIX);
                end
                item.last = (i == digits.size() - 1);
                pending_chars.push_back(item);
            end
        endfunction

        function void check_char(input logic [itra_pkg::CHAR_W-1:0] character,
                                 input logic last);
            t_char want;
            chars_checked++;
            if (pending_chars.size() == 0) begin
                $error("unexpected item: character 0x%02h last %0b", character, last);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (character !== want.character) begin
                $error("character: expected 0x%02h, actual 0x%02h", want.character, character);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    itra_in_if  in_ch ();
    itra_out_if out_ch ();

    integer_to_radix_ascii dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ascii_digit_board board = new();

    int unsigned values_sent;
    int unsigned neg_decimal_sent;
    int unsigned odd_radix_sent;
    int unsigned holds_done;
    int unsigned idle_cycles;
    bit          tx_steady;
    bit          rx_steady;
    bit          hold_request;
    int          hold_left;
    int          stall_left;

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int gap_len(input bit steady);
        int pick;
        if (steady) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 4);
        end else begin
            return $urandom_range(10, 60);
        end
    endfunction

    function automatic logic signed [itra_pkg::VALUE_BITS-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4:          return $urandom_range(0, 1000);
            5:          return -$signed(itra_pkg::VALUE_BITS'($urandom_range(1, 1000)));
            6: begin
                case ($urandom_range(0, 4))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return '0;
                    3:       return '1;
                    default: return 1;
                endcase
            end
            7:          return $urandom >> $urandom_range(0, itra_pkg::VALUE_BITS - 1);
            default:    return $signed($urandom) >>> $urandom_range(0, itra_pkg::VALUE_BITS - 1);
        endcase
    endfunction

    // Base ten is favoured since only there does a sign appear.
    function automatic logic [itra_pkg::RADIX_W-1:0] random_radix();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: return itra_pkg::DEC_RADIX;
            5:             return itra_pkg::RADIX_MIN;
            6:             return itra_pkg::RADIX_W'(16);
            7:             return itra_pkg::RADIX_MAX;
            8: begin
                if ($urandom_range(0, 1) == 0) begin
                    return itra_pkg::RADIX_W'($urandom_range(0, 1));
                end else begin
                    return itra_pkg::RADIX_W'($urandom_range(37, 63));
                end
            end
            default:       return itra_pkg::RADIX_W'($urandom_range(2, 36));
        endcase
    endfunction

    task automatic send_value(input logic signed [itra_pkg::VALUE_BITS-1:0] value,
                              input logic [itra_pkg::RADIX_W-1:0] radix);
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.radix <= radix;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        board.note_value(value, radix);
        values_sent++;
        if (value < 0 && radix == itra_pkg::DEC_RADIX) begin
            neg_decimal_sent++;
        end
        if (radix < itra_pkg::RADIX_MIN || radix > itra_pkg::RADIX_MAX) begin
            odd_radix_sent++;
        end
    endtask

    task automatic offer_value(input logic signed [itra_pkg::VALUE_BITS-1:0] value,
                               input logic [itra_pkg::RADIX_W-1:0] radix);
        int pause;
        send_value(value, radix);
        pause = gap_len(tx_steady);
        if (pause > 0) begin
            in_ch.valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    task automatic offer_random(input int count);
        repeat (count) begin
            offer_value(random_value(), random_radix());
        end
    endtask

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    initial begin
        out_ch.ready <= 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = gap_len(rx_steady);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_char(out_ch.character, out_ch.last);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("integer_to_radix_ascii test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.radix <= itra_pkg::DEC_RADIX;
        idle_cycles  = 0;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, the extremes, sign handling and saturation of the radix.
        offer_value('0, itra_pkg::DEC_RADIX);
        offer_value('0, itra_pkg::RADIX_MIN);
        offer_value(MOST_NEG, itra_pkg::DEC_RADIX);
        offer_value(MOST_NEG, itra_pkg::RADIX_MIN);
        offer_value(MOST_NEG, itra_pkg::RADIX_W'(16));
        offer_value(MOST_NEG, itra_pkg::RADIX_MAX);
        offer_value(MOST_POS, itra_pkg::RADIX_MIN);
        offer_value(MOST_POS, itra_pkg::DEC_RADIX);
        offer_value(MOST_POS, itra_pkg::RADIX_MAX);
        offer_value('1, itra_pkg::DEC_RADIX);
        offer_value('1, itra_pkg::RADIX_W'(16));
        offer_value('1, itra_pkg::RADIX_MIN);
        offer_value(1, itra_pkg::RADIX_MAX);
        offer_value(35, itra_pkg::RADIX_MAX);
        offer_value(10, itra_pkg::RADIX_W'(11));
        offer_value(9, itra_pkg::DEC_RADIX);
        offer_value(-32'sd123456789, itra_pkg::DEC_RADIX);
        offer_value(-32'sd123456789, itra_pkg::RADIX_W'(7));
        offer_value(5, itra_pkg::RADIX_W'(0));
        offer_value(-32'sd6, itra_pkg::RADIX_W'(1));
        offer_value(MOST_POS, itra_pkg::RADIX_W'(37));
        offer_value(MOST_NEG, itra_pkg::RADIX_W'(63));

        offer_random(110);

        // Long receiver hold-off while items keep coming, so the input queue fills.
        hold_request = 1'b1;
        tx_steady    = 1'b1;
        offer_random(40);

        // No idling on either side for a while.
        rx_steady = 1'b1;
        offer_random(60);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        offer_random(120);
        in_ch.valid <= 1'b0;

        while (board.pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d values (%0d negative in base ten, %0d with a saturated radix),",
                 values_sent, neg_decimal_sent, odd_radix_sent);
        $display("checked %0d characters, %0d long receiver hold-off(s).",
                 board.chars_checked, holds_done);
        if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
            $display("integer_to_radix_ascii test passed");
        end else begin
            $display("integer_to_radix_ascii test failed");
        end
        $finish;
    end

endmodule

>>> files.f
src/itra_pkg.sv
src/itra_in_if.sv
src/itra_out_if.sv
src/itra_front.sv
src/itra_cmd_fifo.sv
src/itra_back.sv
src/integer_to_radix_ascii.sv
verif/integer_to_radix_ascii_tb.sv
